// File: rtl/csl_pkg.sv
// shared types, codes and constants of the c subset lexer
`default_nettype none

package csl_pkg;

    // default configuration
    localparam int MAX_IDENT_LETTERS = 12;
    localparam int NUMBER_WIDTH      = 32;

    // fixed field widths
    localparam int KIND_W    = 3;
    localparam int SYM_W     = 4;
    localparam int NUM_OUT_W = 32;
    localparam int LETTER_W  = 5;
    localparam int IDENT_LANES = 12;
    localparam int LETTERS_W = LETTER_W * IDENT_LANES;
    localparam int ILEN_W    = 4;
    localparam int CAUSE_W   = 2;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [SYM_W-1:0]     t_sym;
    typedef logic [NUM_OUT_W-1:0] t_number;
    typedef logic [LETTERS_W-1:0] t_letters;
    typedef logic [ILEN_W-1:0]    t_ilen;
    typedef logic [CAUSE_W-1:0]   t_cause;

    // token kinds
    localparam t_kind KIND_NUMBER = 3'd0;
    localparam t_kind KIND_IDENT  = 3'd1;
    localparam t_kind KIND_SYMBOL = 3'd2;
    localparam t_kind KIND_END    = 3'd3;
    localparam t_kind KIND_ERROR  = 3'd4;

    // symbol codes
    localparam t_sym SYM_LE     = 4'd0;
    localparam t_sym SYM_GE     = 4'd1;
    localparam t_sym SYM_EQEQ   = 4'd2;
    localparam t_sym SYM_NE     = 4'd3;
    localparam t_sym SYM_PLUS   = 4'd4;
    localparam t_sym SYM_MINUS  = 4'd5;
    localparam t_sym SYM_STAR   = 4'd6;
    localparam t_sym SYM_SLASH  = 4'd7;
    localparam t_sym SYM_LPAREN = 4'd8;
    localparam t_sym SYM_RPAREN = 4'd9;
    localparam t_sym SYM_LT     = 4'd10;
    localparam t_sym SYM_GT     = 4'd11;
    localparam t_sym SYM_ASSIGN = 4'd12;
    localparam t_sym SYM_SEMI   = 4'd13;

    // error causes
    localparam t_cause CAUSE_NONE     = 2'd0;
    localparam t_cause CAUSE_BAD_CHAR = 2'd1;
    localparam t_cause CAUSE_LONE_NOT = 2'd2;
    localparam t_cause CAUSE_TOO_LONG = 2'd3;

    // held first character of a two-character symbol
    localparam logic [1:0] PSYM_LT   = 2'd0;
    localparam logic [1:0] PSYM_GT   = 2'd1;
    localparam logic [1:0] PSYM_EQ   = 2'd2;
    localparam logic [1:0] PSYM_BANG = 2'd3;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_Z      = 8'h7A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

endpackage

`default_nettype wire

// File: rtl/csl_if.sv
// character and token channel interfaces of the c subset lexer
`default_nettype none

interface csl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface csl_tok_if;
    logic               valid;
    logic               ready;
    csl_pkg::t_kind     token_kind;
    csl_pkg::t_sym      symbol_code;
    csl_pkg::t_number   number_value;
    logic               number_saturated;
    csl_pkg::t_letters  ident_letters;
    csl_pkg::t_ilen     ident_length;
    csl_pkg::t_cause    error_cause;
    logic               last_of_run;

    modport source (
        output valid, output token_kind, output symbol_code, output number_value,
        output number_saturated, output ident_letters, output ident_length,
        output error_cause, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input symbol_code, input number_value,
        input number_saturated, input ident_letters, input ident_length,
        input error_cause, input last_of_run, output ready
    );
endinterface

`default_nettype wire

// File: rtl/c_subset_lexer.sv
// c subset lexer top level: character-serial tokenizer with a result queue
//
//  channel  dir  payload                                      request
//  i_char   in   char_code, end_of_input                      one character or end marker
//  o_tok    out  kind, symbol, number, ident, cause, last     one token
//
// one character is taken per cycle while i_char.ready is high; its tokens (zero,
// one or two) enter a four-entry result queue in the same cycle and leave one per
// cycle. a character that makes two tokens grows the queue, so the sustained rate
// is one request per cycle as long as at most one token a cycle comes out.
// i_char.ready is high while the queue has room for two tokens.
// synchronous active-low reset empties the queue and returns the lexer to idle.
// output stalls fill the queue and drop ready; no token is lost.
`default_nettype none

module c_subset_lexer #(
    parameter int MAX_IDENT_LETTERS = csl_pkg::MAX_IDENT_LETTERS,
    parameter int NUMBER_WIDTH      = csl_pkg::NUMBER_WIDTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    csl_char_if.sink      i_char,
    csl_tok_if.source     o_tok
);

    localparam int PW = NUMBER_WIDTH + 4;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_NUMBER = 5'b00010,
        MODE_IDENT  = 5'b00100,
        MODE_SYMBOL = 5'b01000,
        MODE_ERROR  = 5'b10000
    } t_mode;

    typedef struct packed {
        csl_pkg::t_kind    kind;
        csl_pkg::t_sym     symbol;
        csl_pkg::t_number  number;
        logic              saturated;
        csl_pkg::t_letters letters;
        csl_pkg::t_ilen    length;
        csl_pkg::t_cause   cause;
        logic              last;
    } t_token;

    // lexer state
    t_mode                     r_mode, n_mode;
    logic [NUMBER_WIDTH-1:0]   r_acc, n_acc;
    logic                      r_ovf, n_ovf;
    csl_pkg::t_letters         r_ibuf, n_ibuf;
    csl_pkg::t_ilen            r_icnt, n_icnt;
    logic [1:0]                r_psym, n_psym;

    // result queue
    t_token                    r_q [csl_pkg::QDEPTH];
    logic [csl_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [csl_pkg::QCNT_W-1:0] r_cnt;

    logic       w_accept;
    logic       w_pop;
    logic [7:0] w_c;
    logic       w_eoi;

    // character classes
    logic       w_space, w_digit, w_lower;
    logic [3:0] w_dig;
    logic [csl_pkg::LETTER_W-1:0] w_letter;

    // pending token
    t_token     w_pend;
    logic       w_pend_v, w_pend_err;

    // tokens of this step
    logic       w_emit_a, w_emit_b;
    t_token     w_tok_b;
    t_token     w_t0, w_t1;
    logic [1:0] w_n;

    logic [PW-1:0] w_prod;

    assign w_accept = i_char.valid && i_char.ready;
    assign w_pop    = o_tok.valid && o_tok.ready;
    assign w_c      = i_char.char_code;
    assign w_eoi    = i_char.end_of_input;

    assign i_char.ready = (r_cnt <= csl_pkg::QCNT_W'(csl_pkg::QDEPTH - 2));

    // classify the incoming character
    assign w_space  = (w_c == csl_pkg::CH_SPACE) ||
                      (w_c >= csl_pkg::CH_TAB && w_c <= csl_pkg::CH_CR);
    assign w_digit  = (w_c >= csl_pkg::CH_0) && (w_c <= csl_pkg::CH_9);
    assign w_lower  = (w_c >= csl_pkg::CH_A) && (w_c <= csl_pkg::CH_Z);
    assign w_dig    = 4'(w_c - csl_pkg::CH_0);
    assign w_letter = csl_pkg::LETTER_W'(w_c - csl_pkg::CH_A);

    // acc * 10 + digit, with head room to spot overflow
    assign w_prod = (PW'(r_acc) << 3) + (PW'(r_acc) << 1) + PW'(w_dig);

    // token that a break in the current run would flush
    always_comb begin
        w_pend     = '0;
        w_pend_v   = 1'b0;
        w_pend_err = 1'b0;
        case (r_mode)
            MODE_NUMBER: begin
                w_pend_v         = 1'b1;
                w_pend.kind      = csl_pkg::KIND_NUMBER;
                w_pend.number    = csl_pkg::t_number'(r_acc);
                w_pend.saturated = r_ovf;
            end
            MODE_IDENT: begin
                w_pend_v       = 1'b1;
                w_pend.kind    = csl_pkg::KIND_IDENT;
                w_pend.letters = r_ibuf;
                w_pend.length  = r_icnt;
            end
            MODE_SYMBOL: begin
                w_pend_v = 1'b1;
                if (r_psym == csl_pkg::PSYM_BANG) begin
                    w_pend_err   = 1'b1;
                    w_pend.kind  = csl_pkg::KIND_ERROR;
                    w_pend.cause = csl_pkg::CAUSE_LONE_NOT;
                end else begin
                    w_pend.kind   = csl_pkg::KIND_SYMBOL;
                    w_pend.symbol = csl_pkg::SYM_LT + {2'b00, r_psym};
                end
            end
            default: ;
        endcase
    end

    // one lexer step
    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_ibuf   = r_ibuf;
        n_icnt   = r_icnt;
        n_psym   = r_psym;
        w_emit_a = 1'b0;
        w_emit_b = 1'b0;
        w_tok_b  = '0;
        if (w_accept) begin
            if (w_eoi) begin
                w_emit_a     = w_pend_v;
                w_emit_b     = 1'b1;
                w_tok_b.kind = csl_pkg::KIND_END;
                n_mode       = MODE_IDLE;
            end else if (r_mode == MODE_ERROR) begin
                n_mode = MODE_ERROR;
            end else if (r_mode == MODE_NUMBER && w_digit) begin
                if (r_ovf || (w_prod[PW-1:NUMBER_WIDTH] != '0)) begin
                    n_acc = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_acc = w_prod[NUMBER_WIDTH-1:0];
                end
            end else if (r_mode == MODE_IDENT && w_lower) begin
                if (r_icnt >= csl_pkg::ILEN_W'(MAX_IDENT_LETTERS)) begin
                    w_emit_b      = 1'b1;
                    w_tok_b.kind  = csl_pkg::KIND_ERROR;
                    w_tok_b.cause = csl_pkg::CAUSE_TOO_LONG;
                    n_mode        = MODE_ERROR;
                end else begin
                    for (int i = 0; i < csl_pkg::IDENT_LANES; i++) begin
                        if (r_icnt == csl_pkg::ILEN_W'(i)) begin
                            n_ibuf[i*csl_pkg::LETTER_W +: csl_pkg::LETTER_W] = w_letter;
                        end
                    end
                    n_icnt = r_icnt + csl_pkg::ILEN_W'(1);
                end
            end else if (r_mode == MODE_SYMBOL && w_c == csl_pkg::CH_EQ) begin
                w_emit_b       = 1'b1;
                w_tok_b.kind   = csl_pkg::KIND_SYMBOL;
                w_tok_b.symbol = {2'b00, r_psym};
                n_mode         = MODE_IDLE;
            end else begin
                // flush the run, then start afresh on this character (a lone ! enters error mode instead)
                w_emit_a = w_pend_v;
                if (w_pend_err) begin
                    n_mode = MODE_ERROR;
                end else begin
                    n_mode = MODE_IDLE;
                    if (w_space) begin
                        n_mode = MODE_IDLE;
                    end else if (w_digit) begin
                        n_mode = MODE_NUMBER;
                        n_acc  = NUMBER_WIDTH'(w_dig);
                        n_ovf  = 1'b0;
                    end else if (w_lower) begin
                        n_mode = MODE_IDENT;
                        n_ibuf = csl_pkg::LETTERS_W'(w_letter);
                        n_icnt = csl_pkg::ILEN_W'(1);
                    end else begin
                        w_tok_b.kind = csl_pkg::KIND_SYMBOL;
                        case (w_c)
                            csl_pkg::CH_LT: begin
                                n_mode = MODE_SYMBOL;
                                n_psym = csl_pkg::PSYM_LT;
                            end
                            csl_pkg::CH_GT: begin
                                n_mode = MODE_SYMBOL;
                                n_psym = csl_pkg::PSYM_GT;
                            end
                            csl_pkg::CH_EQ: begin
                                n_mode = MODE_SYMBOL;
                                n_psym = csl_pkg::PSYM_EQ;
                            end
                            csl_pkg::CH_BANG: begin
                                n_mode = MODE_SYMBOL;
                                n_psym = csl_pkg::PSYM_BANG;
                            end
                            csl_pkg::CH_PLUS: begin
                                w_emit_b       = 1'b1;
                                w_tok_b.symbol = csl_pkg::SYM_PLUS;
                            end
                            csl_pkg::CH_MINUS: begin
                                w_emit_b       = 1'b1;
                                w_tok_b.symbol = csl_pkg::SYM_MINUS;
                            end
                            csl_pkg::CH_STAR: begin
                                w_emit_b       = 1'b1;
                                w_tok_b.symbol = csl_pkg::SYM_STAR;
                            end
                            csl_pkg::CH_SLASH: begin
                                w_emit_b       = 1'b1;
                                w_tok_b.symbol = csl_pkg::SYM_SLASH;
                            end
                            csl_pkg::CH_LPAREN: begin
                                w_emit_b       = 1'b1;
                                w_tok_b.symbol = csl_pkg::SYM_LPAREN;
                            end
                            csl_pkg::CH_RPAREN: begin
                                w_emit_b       = 1'b1;
                                w_tok_b.symbol = csl_pkg::SYM_RPAREN;
                            end
                            csl_pkg::CH_SEMI: begin
                                w_emit_b       = 1'b1;
                                w_tok_b.symbol = csl_pkg::SYM_SEMI;
                            end
                            default: begin
                                w_emit_b      = 1'b1;
                                w_tok_b.kind  = csl_pkg::KIND_ERROR;
                                w_tok_b.cause = csl_pkg::CAUSE_BAD_CHAR;
                                n_mode        = MODE_ERROR;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // pack the step's tokens and mark the last one
    always_comb begin
        w_n  = {1'b0, w_emit_a} + {1'b0, w_emit_b};
        w_t0 = w_emit_a ? w_pend : w_tok_b;
        w_t1 = w_tok_b;
        w_t0.last = (w_n == 2'd1);
        w_t1.last = 1'b1;
    end

    // lexer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
            r_ibuf <= '0;
            r_icnt <= '0;
            r_psym <= '0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
            r_ibuf <= n_ibuf;
            r_icnt <= n_icnt;
            r_psym <= n_psym;
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + csl_pkg::QPTR_W'(w_n);
            r_rp  <= r_rp + csl_pkg::QPTR_W'(w_pop);
            r_cnt <= r_cnt + csl_pkg::QCNT_W'(w_n) - csl_pkg::QCNT_W'(w_pop);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (w_n != 2'd0) begin
            r_q[r_wp] <= w_t0;
        end
        if (w_n == 2'd2) begin
            r_q[r_wp + csl_pkg::QPTR_W'(1)] <= w_t1;
        end
    end

    // head of the queue drives the token channel
    assign o_tok.valid            = (r_cnt != '0);
    assign o_tok.token_kind       = r_q[r_rp].kind;
    assign o_tok.symbol_code      = r_q[r_rp].symbol;
    assign o_tok.number_value     = r_q[r_rp].number;
    assign o_tok.number_saturated = r_q[r_rp].saturated;
    assign o_tok.ident_letters    = r_q[r_rp].letters;
    assign o_tok.ident_length     = r_q[r_rp].length;
    assign o_tok.error_cause      = r_q[r_rp].cause;
    assign o_tok.last_of_run      = r_q[r_rp].last;

`ifndef SYNTHESIS
    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= csl_pkg::QCNT_W'(csl_pkg::QDEPTH))
        else $error("result queue overflow");

    // end marker always returns the lexer to idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_eoi |=> r_mode == MODE_IDLE)
        else $error("lexer not idle after end marker");

    // characters in error mode make no tokens
    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_eoi && r_mode == MODE_ERROR |-> w_n == 2'd0)
        else $error("token made in error mode");

    // identifier length stays within the limit
    a_ident_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_IDENT |-> r_icnt <= csl_pkg::ILEN_W'(MAX_IDENT_LETTERS))
        else $error("identifier count beyond limit");
`endif

endmodule

`default_nettype wire
